>>> rtl/rhg_pkg.sv
// Package: types, constants and helpers for the Robin Hood glyph hash table.
package rhg_pkg;

   localparam int CAPACITY     = 1024;
   localparam int PAYLOAD_BITS = 32;
   localparam int SLOT_BITS    = $clog2(CAPACITY);
   localparam int CNT_BITS     = SLOT_BITS + 1;
   localparam logic [CNT_BITS-1:0]  FULL_LIMIT = CNT_BITS'(CAPACITY * 3 / 4);
   localparam logic [SLOT_BITS-1:0] SLOT_MAX   = SLOT_BITS'(CAPACITY - 1);

   localparam logic [31:0] K_GLYPH = 32'd2654435761;
   localparam logic [63:0] K_FMIX1 = 64'hff51afd7ed558ccd;
   localparam logic [63:0] K_FMIX2 = 64'hc4ceb9fe1a85ec53;

   typedef enum logic [1:0] {
      CMD_FIND       = 2'd0,
      CMD_GET_INSERT = 2'd1,
      CMD_WRITE      = 2'd2,
      CMD_SPARE      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2,
      STAT_RSVD = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      TS_CLEAR,
      TS_IDLE,
      TS_HASH,
      TS_LK_RD,
      TS_LK_CHK,
      TS_IN_RD,
      TS_IN_CHK
   } tbl_state_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] font_id;
      logic [31:0] glyph_code;
      logic [31:0] value_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        was_new;
      logic [9:0]  slot_index;
      logic [31:0] value_out;
   } rsp_type;

   typedef struct packed {
      logic [63:0]             hash;
      logic [31:0]             font;
      logic [31:0]             glyph;
      logic [PAYLOAD_BITS-1:0] payload;
   } entry_type;

   function automatic logic [63:0] xs33(input logic [63:0] x);
      return x ^ (x >> 33);
   endfunction

endpackage

>>> rtl/robin_hood_glyph_hash_table_top.sv
// Top level: hash unit, probe sequencer and the registered result beat.
//
//  channel   ports                     beat taken when
//  request   start, busy, req_data     start && !busy at a rising edge
//  result    rsp_strobe, rsp_data      rsp_strobe high, one cycle, no stall
//
// Per command: accept cycle, 10 shared-multiplier hash steps, a hand-over to the
// probe, a read state and a check state for each slot probed, another read and
// check for each slot walked by an insert, then the registered result beat.
// After reset the block clears all 1024 slots, one a cycle, with busy high.
// Reset is synchronous, active high; results cannot be held off.
module robin_hood_glyph_hash_table_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  rhg_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_strobe,
   output rhg_pkg::rsp_type rsp_data
);

   logic             hash_start, hash_done, fin_valid;
   logic [63:0]      hash;
   rhg_pkg::rsp_type fin_data;
   logic             rsp_strobe_ff;
   rhg_pkg::rsp_type rsp_data_ff;

   rhg_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .font  (req_data.font_id),
      .glyph (req_data.glyph_code),
      .done  (hash_done),
      .hash  (hash)
   );

   rhg_table u_table (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .hash_start (hash_start),
      .hash_done  (hash_done),
      .hash       (hash),
      .fin_valid  (fin_valid),
      .fin_data   (fin_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= fin_valid;
      end
      rsp_data_ff <= fin_data;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

>>> rtl/rhg_hash.sv
// Iterative key hash: one shared 32x32 multiplier stepped through the mix and finalizer.
module rhg_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] font,
   input  logic [31:0] glyph,
   output logic        done,
   output logic [63:0] hash
);

   localparam logic [31:0] K_FMIX1_LO = rhg_pkg::K_FMIX1[31:0];

   logic [3:0]  step_ff, step_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [31:0] font_ff, font_in, glyph_ff, glyph_in;
   logic [63:0] prod_ff, prod_in, acc_ff, acc_in, h_ff, h_in;
   logic [31:0] mul_a, mul_b;
   logic [63:0] sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      font_ff  <= font_in;
      glyph_ff <= glyph_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      h_ff     <= h_in;
   end

   always_comb begin
      unique case (step_ff)
         4'd0:                      mul_a = glyph_ff;
         4'd4, 4'd8:                mul_a = h_ff[63:32];
         default:                   mul_a = h_ff[31:0];
      endcase
      unique case (step_ff)
         4'd2, 4'd4:                mul_b = K_FMIX1_LO;
         4'd3:                      mul_b = rhg_pkg::K_FMIX1[63:32];
         4'd6, 4'd8:                mul_b = rhg_pkg::K_FMIX2[31:0];
         4'd7:                      mul_b = rhg_pkg::K_FMIX2[63:32];
         default:                   mul_b = rhg_pkg::K_GLYPH;
      endcase
   end

   assign sum = acc_ff + {prod_ff[31:0], 32'd0};

   always_comb begin
      step_in  = step_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      font_in  = font_ff;
      glyph_in = glyph_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      h_in     = h_ff;
      if (start && !run_ff) begin
         font_in  = font;
         glyph_in = glyph;
         step_in  = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         prod_in = mul_a * mul_b;
         step_in = step_ff + 4'd1;
         unique case (step_ff)
            4'd1:       h_in = rhg_pkg::xs33({32'd0, font_ff} ^ prod_ff);
            4'd3, 4'd7: acc_in = prod_ff;
            4'd4, 4'd8: acc_in = sum;
            4'd5:       h_in = rhg_pkg::xs33(sum);
            4'd9: begin
               h_in    = rhg_pkg::xs33(sum) | 64'd1;
               run_in  = 1'b0;
               done_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign done = done_ff;
   assign hash = h_ff;

   a_done_pulse: assert property (@(posedge clock) disable iff (reset) done_ff |=> !done_ff)
      else $error("hash done held");
   a_done_odd: assert property (@(posedge clock) disable iff (reset) done_ff |-> h_ff[0])
      else $error("hash bit 0 clear at done");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> step_ff <= 4'd9)
      else $error("hash step out of range");

endmodule

>>> rtl/rhg_table.sv
// Slot memory and probe sequencer: clearing pass, lookup walk and Robin Hood insert.
module rhg_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  rhg_pkg::req_type req_data,
   output logic             busy,
   output logic             hash_start,
   input  logic             hash_done,
   input  logic [63:0]      hash,
   output logic             fin_valid,
   output rhg_pkg::rsp_type fin_data
);

   localparam int SB = rhg_pkg::SLOT_BITS;

   rhg_pkg::entry_type mem [rhg_pkg::CAPACITY];
   rhg_pkg::entry_type rd_ff, wd, carry_ff, carry_in;
   logic               we;
   logic [SB-1:0]      wa, ra;

   rhg_pkg::tbl_state_type state_ff, state_in;
   rhg_pkg::req_type       req_ff, req_in;
   logic [SB-1:0]          idx_ff, idx_in, dist_ff, dist_in, n_ff, n_in;
   logic [SB-1:0]          landed_ff, landed_in, clr_ff, clr_in;
   logic                   placed_ff, placed_in;
   logic [rhg_pkg::CNT_BITS-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rhg_pkg::TS_CLEAR;
         clr_ff    <= '0;
         count_ff  <= '0;
         placed_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         count_ff  <= count_in;
         placed_ff <= placed_in;
      end
      req_ff    <= req_in;
      idx_ff    <= idx_in;
      dist_ff   <= dist_in;
      n_ff      <= n_in;
      landed_ff <= landed_in;
      carry_ff  <= carry_in;
   end

   always_comb begin
      logic          empty, match, found, miss;
      logic [SB-1:0] resident, dist_nx, land_nx;
      state_in   = state_ff;
      req_in     = req_ff;
      idx_in     = idx_ff;
      dist_in    = dist_ff;
      n_in       = n_ff;
      landed_in  = landed_ff;
      placed_in  = placed_ff;
      carry_in   = carry_ff;
      clr_in     = clr_ff;
      count_in   = count_ff;
      we         = 1'b0;
      wa         = idx_ff;
      wd         = carry_ff;
      ra         = idx_ff;
      hash_start = 1'b0;
      fin_valid  = 1'b0;
      fin_data   = '0;
      empty      = (rd_ff.hash == 64'd0);
      match      = (rd_ff.hash == hash) && (rd_ff.font == req_ff.font_id)
                   && (rd_ff.glyph == req_ff.glyph_code);
      resident   = idx_ff - rd_ff.hash[SB-1:0];
      found      = 1'b0;
      miss       = 1'b0;
      dist_nx    = dist_ff;
      land_nx    = landed_ff;
      unique case (state_ff)
         rhg_pkg::TS_CLEAR: begin
            we     = 1'b1;
            wa     = clr_ff;
            wd     = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == rhg_pkg::SLOT_MAX) state_in = rhg_pkg::TS_IDLE;
         end
         rhg_pkg::TS_IDLE: begin
            if (start) begin
               req_in     = req_data;
               hash_start = 1'b1;
               state_in   = rhg_pkg::TS_HASH;
            end
         end
         rhg_pkg::TS_HASH: begin
            if (hash_done) begin
               idx_in   = hash[SB-1:0];
               dist_in  = '0;
               state_in = rhg_pkg::TS_LK_RD;
            end
         end
         rhg_pkg::TS_LK_RD: state_in = rhg_pkg::TS_LK_CHK;
         rhg_pkg::TS_LK_CHK: begin
            priority if (empty)                      miss  = 1'b1;
            else if (match)                          found = 1'b1;
            else if (resident < dist_ff)             miss  = 1'b1;
            else if (dist_ff == rhg_pkg::SLOT_MAX)   miss  = 1'b1;
            else begin
               idx_in   = idx_ff + 1'b1;
               dist_in  = dist_ff + 1'b1;
               state_in = rhg_pkg::TS_LK_RD;
            end
            if (found) begin
               fin_valid           = 1'b1;
               fin_data.status     = rhg_pkg::STAT_OK;
               fin_data.slot_index = 10'(idx_ff);
               fin_data.value_out  = 32'(rd_ff.payload);
               if (req_ff.cmd == rhg_pkg::CMD_WRITE) begin
                  we         = 1'b1;
                  wd         = rd_ff;
                  wd.payload = rhg_pkg::PAYLOAD_BITS'(req_ff.value_in);
                  fin_data.value_out = 32'(wd.payload);
               end
               state_in = rhg_pkg::TS_IDLE;
            end else if (miss) begin
               if (req_ff.cmd != rhg_pkg::CMD_GET_INSERT) begin
                  fin_valid       = 1'b1;
                  fin_data.status = rhg_pkg::STAT_MISS;
                  state_in        = rhg_pkg::TS_IDLE;
               end else if (count_ff >= rhg_pkg::FULL_LIMIT) begin
                  fin_valid       = 1'b1;
                  fin_data.status = rhg_pkg::STAT_FULL;
                  state_in        = rhg_pkg::TS_IDLE;
               end else begin
                  carry_in.hash    = hash;
                  carry_in.font    = req_ff.font_id;
                  carry_in.glyph   = req_ff.glyph_code;
                  carry_in.payload = '0;
                  idx_in    = hash[SB-1:0];
                  dist_in   = '0;
                  n_in      = '0;
                  placed_in = 1'b0;
                  state_in  = rhg_pkg::TS_IN_RD;
               end
            end
         end
         rhg_pkg::TS_IN_RD: state_in = rhg_pkg::TS_IN_CHK;
         rhg_pkg::TS_IN_CHK: begin
            if (empty) begin
               we                  = 1'b1;
               count_in            = count_ff + 1'b1;
               fin_valid           = 1'b1;
               fin_data.status     = rhg_pkg::STAT_OK;
               fin_data.was_new    = 1'b1;
               fin_data.slot_index = 10'(placed_ff ? landed_ff : idx_ff);
               state_in            = rhg_pkg::TS_IDLE;
            end else begin
               // richer resident gives up its slot and travels on
               if (resident < dist_ff) begin
                  we       = 1'b1;
                  carry_in = rd_ff;
                  dist_nx  = resident;
                  if (!placed_ff) begin
                     placed_in = 1'b1;
                     land_nx   = idx_ff;
                  end
               end
               landed_in = land_nx;
               dist_in   = dist_nx + 1'b1;
               idx_in    = idx_ff + 1'b1;
               n_in      = n_ff + 1'b1;
               if (n_ff == rhg_pkg::SLOT_MAX) begin
                  fin_valid           = 1'b1;
                  fin_data.status     = rhg_pkg::STAT_OK;
                  fin_data.was_new    = 1'b1;
                  fin_data.slot_index = 10'(land_nx);
                  state_in            = rhg_pkg::TS_IDLE;
               end else begin
                  state_in = rhg_pkg::TS_IN_RD;
               end
            end
         end
         default: state_in = rhg_pkg::TS_IDLE;
      endcase
   end

   assign busy = (state_ff != rhg_pkg::TS_IDLE);

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= rhg_pkg::FULL_LIMIT)
      else $error("entry count above load limit");
   a_fin_state: assert property (@(posedge clock) disable iff (reset)
      fin_valid |-> (state_ff == rhg_pkg::TS_LK_CHK || state_ff == rhg_pkg::TS_IN_CHK))
      else $error("result outside a check state");
   a_landed_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rhg_pkg::TS_IN_CHK && placed_ff) |=> $stable(landed_ff))
      else $error("landing slot moved after placement");
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      we |-> (state_ff == rhg_pkg::TS_CLEAR || state_ff == rhg_pkg::TS_LK_CHK
              || state_ff == rhg_pkg::TS_IN_CHK))
      else $error("slot write outside clear or check");

endmodule

>>> tb/sv/tb_robin_hood_glyph_hash_table_top.sv
// Testbench: Robin Hood glyph hash table, command beats checked against a behavioral table.
module tb_robin_hood_glyph_hash_table_top;

   localparam int MAX_CYCLES = 3000000;

   logic             clock;
   logic             reset;
   logic             start;
   rhg_pkg::req_type req_data;
   logic             busy;
   logic             rsp_strobe;
   rhg_pkg::rsp_type rsp_data;

   robin_hood_glyph_hash_table_top i_dut (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data),
      .busy(busy), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   // behavioral table state
   logic [63:0] tbl_hash  [rhg_pkg::CAPACITY];
   logic [31:0] tbl_font  [rhg_pkg::CAPACITY];
   logic [31:0] tbl_glyph [rhg_pkg::CAPACITY];
   logic [31:0] tbl_val   [rhg_pkg::CAPACITY];
   int unsigned tbl_count;

   rhg_pkg::rsp_type pending_rsp[$];
   int unsigned mismatches, rsp_seen, beats_sent, cycles;
   int unsigned idle_pct;
   logic [31:0] key_font[$];
   logic [31:0] key_glyph[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [63:0] glyph_hash(input logic [31:0] f, input logic [31:0] g);
      logic [63:0] h;
      h = {32'd0, f} ^ ({32'd0, g} * 64'd2654435761);
      h = h ^ (h >> 33);
      h = h * 64'hff51afd7ed558ccd;
      h = h ^ (h >> 33);
      h = h * 64'hc4ceb9fe1a85ec53;
      h = h ^ (h >> 33);
      return h | 64'd1;
   endfunction

   function automatic logic [9:0] probe_dist(input logic [63:0] h, input logic [9:0] idx);
      return idx - h[9:0];
   endfunction

   function automatic bit find_slot(input logic [63:0] h, input logic [31:0] f,
                                    input logic [31:0] g, output logic [9:0] where);
      logic [9:0] idx;
      int unsigned pdist;
      idx = h[9:0];
      pdist = 0;
      where = '0;
      for (int n = 0; n < rhg_pkg::CAPACITY; n++) begin
         if (tbl_hash[idx] == 64'd0) return 1'b0;
         if (tbl_hash[idx] == h && tbl_font[idx] == f && tbl_glyph[idx] == g) begin
            where = idx;
            return 1'b1;
         end
         if (probe_dist(tbl_hash[idx], idx) < pdist) return 1'b0;
         idx++;
         pdist++;
      end
      return 1'b0;
   endfunction

   function automatic logic [9:0] place_key(input logic [63:0] h, input logic [31:0] f,
                                            input logic [31:0] g);
      logic [63:0] ch, th;
      logic [31:0] cf, cg, cv, tf, tg, tv;
      logic [9:0]  idx, landed, res;
      int unsigned pdist;
      bit placed;
      ch = h; cf = f; cg = g; cv = '0;
      idx = h[9:0]; pdist = 0; placed = 0; landed = '0;
      for (int n = 0; n < rhg_pkg::CAPACITY; n++) begin
         if (tbl_hash[idx] == 64'd0) begin
            tbl_hash[idx] = ch; tbl_font[idx] = cf; tbl_glyph[idx] = cg; tbl_val[idx] = cv;
            tbl_count++;
            return placed ? landed : idx;
         end
         res = probe_dist(tbl_hash[idx], idx);
         if (res < pdist) begin
            th = tbl_hash[idx]; tf = tbl_font[idx]; tg = tbl_glyph[idx]; tv = tbl_val[idx];
            tbl_hash[idx] = ch; tbl_font[idx] = cf; tbl_glyph[idx] = cg; tbl_val[idx] = cv;
            ch = th; cf = tf; cg = tg; cv = tv;
            pdist = res;
            if (!placed) begin
               placed = 1;
               landed = idx;
            end
         end
         idx++;
         pdist++;
      end
      return landed;
   endfunction

   function automatic rhg_pkg::rsp_type table_outcome(input rhg_pkg::req_type rq);
      rhg_pkg::rsp_type r;
      logic [63:0] h;
      logic [9:0]  where;
      r = '0;
      h = glyph_hash(rq.font_id, rq.glyph_code);
      if (find_slot(h, rq.font_id, rq.glyph_code, where)) begin
         if (rq.cmd == rhg_pkg::CMD_WRITE) tbl_val[where] = rq.value_in;
         r.slot_index = where;
         r.value_out  = tbl_val[where];
      end else if (rq.cmd == rhg_pkg::CMD_GET_INSERT) begin
         if (tbl_count * 4 >= rhg_pkg::CAPACITY * 3) r.status = rhg_pkg::STAT_FULL;
         else begin
            r.slot_index = place_key(h, rq.font_id, rq.glyph_code);
            r.was_new = 1'b1;
         end
      end else r.status = rhg_pkg::STAT_MISS;
      return r;
   endfunction

   always @(posedge clock) begin
      rhg_pkg::rsp_type e;
      if (!reset && rsp_strobe) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", rsp_data);
         end else begin
            e = pending_rsp.pop_front();
            if (e.status !== rsp_data.status || e.was_new !== rsp_data.was_new ||
                e.slot_index !== rsp_data.slot_index || e.value_out !== rsp_data.value_out)
            begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp st=%0d new=%0d slot=%0d val=%h",
                            " got st=%0d new=%0d slot=%0d val=%h"},
                           e.status, e.was_new, e.slot_index, e.value_out, rsp_data.status,
                           rsp_data.was_new, rsp_data.slot_index, rsp_data.value_out);
            end
         end
      end
   end

   // start stays high after a beat until the next call idles or drives a new beat
   task automatic send_cmd(input logic [1:0] c, input logic [31:0] f,
                           input logic [31:0] g, input logic [31:0] v);
      rhg_pkg::req_type rq;
      rq.cmd = c; rq.font_id = f; rq.glyph_code = g; rq.value_in = v;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp.push_back(table_outcome(rq));
      beats_sent++;
   endtask

   task automatic test_directed();
      send_cmd(rhg_pkg::CMD_FIND, 32'd0, 32'd0, 32'd0);
      send_cmd(rhg_pkg::CMD_WRITE, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      send_cmd(rhg_pkg::CMD_GET_INSERT, 32'd0, 32'd0, 32'd0);
      send_cmd(rhg_pkg::CMD_GET_INSERT, 32'd0, 32'd0, 32'd0);
      send_cmd(rhg_pkg::CMD_GET_INSERT, 32'hffffffff, 32'hffffffff, 32'd0);
      send_cmd(rhg_pkg::CMD_WRITE, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      send_cmd(rhg_pkg::CMD_FIND, 32'hffffffff, 32'hffffffff, 32'h0);
      send_cmd(rhg_pkg::CMD_SPARE, 32'hffffffff, 32'hffffffff, 32'h12345678);
      send_cmd(rhg_pkg::CMD_SPARE, 32'h1, 32'h2, 32'h0);
      send_cmd(rhg_pkg::CMD_WRITE, 32'd0, 32'd0, 32'h0);
      send_cmd(rhg_pkg::CMD_GET_INSERT, 32'h80000000, 32'h00000001, 32'h0);
      send_cmd(rhg_pkg::CMD_FIND, 32'h80000000, 32'h00000001, 32'h0);
      key_font = '{32'd0, 32'hffffffff, 32'h80000000};
      key_glyph = '{32'd0, 32'hffffffff, 32'h1};
   endtask

   task automatic test_random(input int unsigned n, input int unsigned ipct,
                              input int unsigned hot);
      logic [31:0] f, g;
      int unsigned k, sel;
      idle_pct = ipct;
      repeat (n) begin
         sel = $urandom_range(99);
         if (sel < hot && key_font.size() > 0) begin
            k = $urandom_range(key_font.size() - 1);
            f = key_font[k]; g = key_glyph[k];
         end else begin
            // small font ids collide on hash neighborhoods; wide ones cover bits
            f = $urandom_range(1) ? $urandom_range(7) : $urandom;
            g = $urandom;
         end
         sel = $urandom_range(3);
         if (sel == rhg_pkg::CMD_GET_INSERT && key_font.size() < 2000) begin
            key_font.push_back(f); key_glyph.push_back(g);
         end
         send_cmd(sel[1:0], f, g, $urandom);
      end
      idle_pct = 0;
   endtask

   // bulk insert past three-quarter load to reach the full refusal
   task automatic test_fill();
      logic [31:0] g;
      idle_pct = 0;
      repeat (760) begin
         g = $urandom;
         key_font.push_back(32'h5);
         key_glyph.push_back(g);
         send_cmd(rhg_pkg::CMD_GET_INSERT, 32'h5, g, 32'h0);
      end
   endtask

   initial begin
      cycles = 0; mismatches = 0; rsp_seen = 0; beats_sent = 0; idle_pct = 0;
      tbl_count = 0;
      for (int i = 0; i < rhg_pkg::CAPACITY; i++) begin
         tbl_hash[i] = '0; tbl_font[i] = '0; tbl_glyph[i] = '0; tbl_val[i] = '0;
      end
      reset = 1'b1; start = 1'b0; req_data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(150, 0, 50);
      test_random(150, 65, 50);
      test_random(150, 17, 60);
      test_fill();
      test_random(200, 0, 70);
      test_random(100, 65, 70);
      start <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("sent %0d command beats, %0d result beats, table held %0d entries",
               beats_sent, rsp_seen, tbl_count);
      $display("covered find, get-or-insert, payload write, spare code, miss and full refusal");
      if (mismatches == 0 && pending_rsp.size() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
